// File: sv/cpsq_pkg.sv
`timescale 1ns / 1ps

package cpsq_pkg;

  // Request and tick codes carried in the operation field.
  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SET_CAM   = 3'd1,
    OP_SET_SENS  = 3'd2,
    OP_START     = 3'd3,
    OP_STOP      = 3'd4,
    OP_PHOTO     = 3'd5
  } op_e;

  // Command that is waiting for or going through its pulse.
  typedef enum logic [2:0] {
    CMD_IDLE       = 3'd0,
    CMD_CAM_ONCE   = 3'd1,
    CMD_CAM_TWICE  = 3'd2,
    CMD_SENSOR     = 3'd3,
    CMD_START_STOP = 3'd4
  } cmd_e;

  // Camera modes; they cycle video, burst, photo.
  localparam logic [1:0] MODE_VIDEO = 2'd0;
  localparam logic [1:0] MODE_BURST = 2'd1;
  localparam logic [1:0] MODE_PHOTO = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MODE_PULSE   = 3'd0;
  localparam logic [2:0] REG_SENSOR_PULSE = 3'd1;
  localparam logic [2:0] REG_SS_PULSE     = 3'd2;
  localparam logic [2:0] REG_COOL_DOWN    = 3'd3;
  localparam logic [2:0] REG_LEVEL_LOW    = 3'd4;
  localparam logic [2:0] REG_LEVEL_HIGH   = 3'd5;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LEVEL_W    = 11;
  localparam int MS_W       = 16;

  // Reset values of the configuration registers.
  localparam logic [MS_W-1:0]           RST_MODE_PULSE   = 16'd1000;
  localparam logic [MS_W-1:0]           RST_SENSOR_PULSE = 16'd1000;
  localparam logic [MS_W-1:0]           RST_SS_PULSE     = 16'd1000;
  localparam logic [MS_W-1:0]           RST_COOL_DOWN    = 16'd500;
  localparam logic signed [LEVEL_W-1:0] RST_LEVEL_LOW    = -11'sd256;
  localparam logic signed [LEVEL_W-1:0] RST_LEVEL_HIGH   = 11'sd256;

  typedef struct packed {
    logic [MS_W-1:0]           mode_pulse_ms;
    logic [MS_W-1:0]           sensor_pulse_ms;
    logic [MS_W-1:0]           start_stop_pulse_ms;
    logic [MS_W-1:0]           cool_down_ms;
    logic signed [LEVEL_W-1:0] level_low;
    logic signed [LEVEL_W-1:0] level_high;
  } cfg_t;

  typedef struct packed {
    logic                      sensor_flipped;
    logic [1:0]                cam_mode;
    logic                      recording;
    logic                      busy_res;
    logic                      pulse_high;
    logic signed [LEVEL_W-1:0] drive_level;
    logic                      accepted;
  } res_t;

  localparam int RES_W = $bits(res_t);

endpackage

// File: sv/cpsq_ctrl.sv
`timescale 1ns / 1ps

module cpsq_ctrl #(
  parameter int TIME_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  cpsq_pkg::op_e             op_i,
  input  logic [1:0]                mode_i,
  input  logic [cpsq_pkg::MS_W-1:0] now_i,
  input  cpsq_pkg::cfg_t            cfg_i,
  output cpsq_pkg::res_t            res_o
);
  import cpsq_pkg::*;

  localparam int NW = (TIME_BITS > MS_W) ? TIME_BITS : MS_W;
  localparam int CW = (TIME_BITS > MS_W + 1) ? TIME_BITS : MS_W + 1;

  cmd_e                  pend_q, pend_d;
  logic [TIME_BITS-1:0]  start_q, start_d;
  logic [MS_W-1:0]       dur_q, dur_d;
  logic                  cool_q, cool_d;
  logic                  level_q, level_d;
  logic [1:0]            cam_q, cam_d;
  logic                  flip_q, flip_d;
  logic                  rec_q, rec_d;

  logic [NW-1:0]         now_w;
  logic [TIME_BITS-1:0]  now_t;
  logic [TIME_BITS-1:0]  delta;
  logic [CW-1:0]         delta_x;
  logic [CW-1:0]         dur_x;
  logic [CW-1:0]         wait_x;
  logic                  busy;
  logic                  ok;
  logic [1:0]            cam_next;
  cmd_e                  load_cmd;
  logic                  load;

  // Timestamp taken modulo the time width; elapsed time wraps the same way.
  assign now_w   = NW'(now_i);
  assign now_t   = now_w[TIME_BITS-1:0];
  assign delta   = now_t - start_q;
  assign delta_x = CW'(delta);
  assign dur_x   = CW'(dur_q);
  assign wait_x  = CW'(dur_q) + CW'(cfg_i.cool_down_ms);

  assign busy     = (pend_q != CMD_IDLE);
  assign cam_next = (cam_q >= MODE_PHOTO) ? MODE_VIDEO : cam_q + 2'd1;

  // Request checks and tick sequencing.
  always_comb begin
    pend_d   = pend_q;
    start_d  = start_q;
    dur_d    = dur_q;
    cool_d   = cool_q;
    level_d  = level_q;
    cam_d    = cam_q;
    flip_d   = flip_q;
    rec_d    = rec_q;
    ok       = 1'b0;
    load     = 1'b0;
    load_cmd = CMD_START_STOP;
    case (op_i)
      OP_TICK: begin
        ok = 1'b1;
        if (busy) begin
          if (!level_q && !cool_q) begin
            level_d = 1'b1;
            start_d = now_t;
          end else if (delta_x >= dur_x) begin
            if (!cool_q) begin
              level_d = 1'b0;
              cool_d  = 1'b1;
              case (pend_q)
                CMD_CAM_ONCE, CMD_CAM_TWICE: cam_d = cam_next;
                CMD_SENSOR:                  flip_d = ~flip_q;
                CMD_START_STOP: begin
                  if (cam_q != MODE_PHOTO) rec_d = ~rec_q;
                end
                default: ;
              endcase
            end else if (delta_x >= wait_x) begin
              cool_d = 1'b0;
              if (pend_q == CMD_CAM_TWICE) begin
                pend_d  = CMD_CAM_ONCE;
                start_d = now_t;
              end else begin
                pend_d = CMD_IDLE;
              end
            end
          end
        end
      end
      OP_SET_CAM: begin
        if (!busy && !rec_q && mode_i <= MODE_PHOTO) begin
          ok = 1'b1;
          if (mode_i != cam_q) begin
            load     = 1'b1;
            load_cmd = (mode_i == cam_next) ? CMD_CAM_ONCE : CMD_CAM_TWICE;
          end
        end
      end
      OP_SET_SENS: begin
        if (!busy && !rec_q && mode_i <= 2'd1) begin
          ok = 1'b1;
          if (mode_i[0] != flip_q) begin
            load     = 1'b1;
            load_cmd = CMD_SENSOR;
          end
        end
      end
      OP_START: begin
        if (!busy && !rec_q && cam_q != MODE_PHOTO) begin
          ok   = 1'b1;
          load = 1'b1;
        end
      end
      OP_STOP: begin
        if (!busy && rec_q && cam_q != MODE_PHOTO) begin
          ok   = 1'b1;
          load = 1'b1;
        end
      end
      OP_PHOTO: begin
        if (!busy && cam_q == MODE_PHOTO) begin
          ok   = 1'b1;
          load = 1'b1;
        end
      end
      default: ;
    endcase

    // Latch the command and its pulse length on an accepted request.
    if (load) begin
      pend_d = load_cmd;
      case (load_cmd)
        CMD_CAM_ONCE, CMD_CAM_TWICE: dur_d = cfg_i.mode_pulse_ms;
        CMD_SENSOR:                  dur_d = cfg_i.sensor_pulse_ms;
        default:                     dur_d = cfg_i.start_stop_pulse_ms;
      endcase
    end
  end

  // Status after the word has been applied.
  always_comb begin
    res_o.accepted       = ok;
    res_o.drive_level    = level_d ? cfg_i.level_high : cfg_i.level_low;
    res_o.pulse_high     = level_d;
    res_o.busy_res       = (pend_d != CMD_IDLE);
    res_o.recording      = rec_d;
    res_o.cam_mode       = cam_d;
    res_o.sensor_flipped = flip_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= CMD_IDLE;
      start_q <= '0;
      dur_q   <= '0;
      cool_q  <= 1'b0;
      level_q <= 1'b0;
      cam_q   <= MODE_VIDEO;
      flip_q  <= 1'b0;
      rec_q   <= 1'b0;
    end else if (en_i) begin
      pend_q  <= pend_d;
      start_q <= start_d;
      dur_q   <= dur_d;
      cool_q  <= cool_d;
      level_q <= level_d;
      cam_q   <= cam_d;
      flip_q  <= flip_d;
      rec_q   <= rec_d;
    end
  end

endmodule

// File: sv/camera_control_pulse_sequencer_core.sv
`timescale 1ns / 1ps

// Camera control pulse sequencer.
// Input words arrive on the s_axis channel: tuser carries the operation (tick or one of
// the requests), tdata the requested mode and the millisecond timestamp used by ticks.
// Every input word yields exactly one result word on the m_axis channel with the accept
// flag, the control line drive value and the tracked camera status after that word.
// The user must write settings through the cfg port while no word is in flight; the
// block itself does not enforce this. A word passes the input register, then the status
// update and the result register; one is taken every cycle while m_axis is not stalled,
// a rate set by the single state update between the input and result registers.
// A stalled m_axis receiver holds the result register; the input register still
// accepts one more word, after which s_axis_tready drops until the result is taken.
// Reset clears both registers, the tracked status (video mode, normal sensor, not
// recording, no pending command) and loads the default pulse lengths and levels.
module camera_control_pulse_sequencer_core #(
  parameter int TIME_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Configuration writes
  input  logic                           cfg_we_i,
  input  logic [cpsq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cpsq_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // Input words
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // mode_value[1:0], now_ms[17:2]
  input  logic [2:0]                     s_axis_tuser,  // operation[2:0]
  // Result words
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // accepted[0], drive_level[11:1], pulse_high[12], busy_res[13], recording[14],
  // cam_mode[16:15], sensor_flipped[17]
  output logic [23:0]                    m_axis_tdata
);
  import cpsq_pkg::*;

  cfg_t            cfg_q;
  logic            in_vld_q;
  op_e             op_q;
  logic [1:0]      mode_q;
  logic [MS_W-1:0] now_q;
  logic            out_vld_q;
  res_t            res_q;
  res_t            res;
  logic            out_free;
  logic            adv;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode_pulse_ms       <= RST_MODE_PULSE;
      cfg_q.sensor_pulse_ms     <= RST_SENSOR_PULSE;
      cfg_q.start_stop_pulse_ms <= RST_SS_PULSE;
      cfg_q.cool_down_ms        <= RST_COOL_DOWN;
      cfg_q.level_low           <= RST_LEVEL_LOW;
      cfg_q.level_high          <= RST_LEVEL_HIGH;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MODE_PULSE:   cfg_q.mode_pulse_ms       <= cfg_data_i;
        REG_SENSOR_PULSE: cfg_q.sensor_pulse_ms     <= cfg_data_i;
        REG_SS_PULSE:     cfg_q.start_stop_pulse_ms <= cfg_data_i;
        REG_COOL_DOWN:    cfg_q.cool_down_ms        <= cfg_data_i;
        REG_LEVEL_LOW:    cfg_q.level_low           <= cfg_data_i[LEVEL_W-1:0];
        REG_LEVEL_HIGH:   cfg_q.level_high          <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign out_free      = !out_vld_q || m_axis_tready;
  assign adv           = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      op_q   <= op_e'(s_axis_tuser);
      mode_q <= s_axis_tdata[1:0];
      now_q  <= s_axis_tdata[MS_W+1:2];
    end
  end

  cpsq_ctrl #(
    .TIME_BITS(TIME_BITS)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .op_i   (op_q),
    .mode_i (mode_q),
    .now_i  (now_q),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(24 - RES_W)'(0), res_q};

endmodule
